[rtl/lbpd_pkg.sv]
// lbpd_pkg: shared types, field widths and register codes of the label border pixel detector
// no dependencies; imported by the chain cells and the top level
`default_nettype none

package lbpd_pkg;

   // fixed field widths
   localparam int LABEL_PORT_BITS = 16;
   localparam int IDX_BITS        = 22;
   localparam int COORD_BITS      = 11;
   localparam int DIM_BITS        = 12;
   localparam int CSR_INDEX_BITS  = 1;

   // image size limits and reset values
   localparam int DIM_MIN        = 3;
   localparam int DIM_MAX        = 2048;
   localparam int WIDTH_DEFAULT  = 640;
   localparam int HEIGHT_DEFAULT = 480;

   // four face neighbors, one compare cell each
   localparam int NB_COUNT = 4;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   // control word that travels down the compare chain
   typedef struct packed {
      logic                valid;
      logic                hit;
      logic [IDX_BITS-1:0] idx;
   } cell_ctl_type;

   // saturate a written dimension into DIM_MIN..hi
   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                     input logic [DIM_BITS-1:0] hi);
      logic [DIM_BITS-1:0] r;
      if (v < DIM_BITS'(DIM_MIN)) begin
         r = DIM_BITS'(DIM_MIN);
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/lbpd_line_ram.sv]
// lbpd_line_ram: one-row label line buffer, one write port and two registered read ports
// no dependencies; read data returns the old contents when an address is read and written
`default_nettype none

module lbpd_line_ram #(
   parameter int  DEPTH     = 2048,
   parameter int  DATA_BITS = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [ADDR_BITS-1:0]      wr_addr,
   input  wire [DATA_BITS-1:0]      wr_data,
   input  wire                      rd_en,
   input  wire [ADDR_BITS-1:0]      rd_a_addr,
   input  wire [ADDR_BITS-1:0]      rd_b_addr,
   output logic [DATA_BITS-1:0]     rd_a_data,
   output logic [DATA_BITS-1:0]     rd_b_data
);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_a_ff;
   logic [DATA_BITS-1:0] rd_b_ff;

   // read-first storage
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_a_addr];
         rd_b_ff <= mem_ff[rd_b_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

`default_nettype wire

[rtl/lbpd_cell.sv]
// lbpd_cell: one compare cell of the neighbor chain; tests one neighbor against the center
// depends on lbpd_pkg for the chain control word and the neighbor count
`default_nettype none

module lbpd_cell #(
   parameter int LABEL_BITS = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          enable,
   input  lbpd_pkg::cell_ctl_type       ctl_i,
   input  wire [LABEL_BITS-1:0]         centre_i,
   input  wire [LABEL_BITS-1:0]         nb_i [lbpd_pkg::NB_COUNT],
   output lbpd_pkg::cell_ctl_type       ctl_o,
   output logic [LABEL_BITS-1:0]        centre_o,
   output logic [LABEL_BITS-1:0]        nb_o [lbpd_pkg::NB_COUNT]
);

   import lbpd_pkg::*;

   logic                  valid_ff;
   logic                  hit_ff;
   logic                  hit_in;
   logic [IDX_BITS-1:0]   idx_ff;
   logic [LABEL_BITS-1:0] centre_ff;
   logic [LABEL_BITS-1:0] nb_ff [NB_COUNT];

   // compare the head neighbor and fold into the running hit
   assign hit_in = ctl_i.hit | (nb_i[0] != centre_i);

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= ctl_i.valid;
      end
   end

   // payload, neighbors shift one place toward the head
   always_ff @(posedge clock) begin
      if (enable) begin
         hit_ff    <= hit_in;
         idx_ff    <= ctl_i.idx;
         centre_ff <= centre_i;
         for (int k = 0; k < NB_COUNT - 1; k++) begin
            nb_ff[k] <= nb_i[k + 1];
         end
         nb_ff[NB_COUNT - 1] <= '0;
      end
   end

   assign ctl_o.valid = valid_ff;
   assign ctl_o.hit   = hit_ff;
   assign ctl_o.idx   = idx_ff;
   assign centre_o    = centre_ff;
   assign nb_o        = nb_ff;

endmodule

`default_nettype wire

[rtl/label_border_pixel_detector_core.sv]
// label_border_pixel_detector_core: 4-neighbor label border detector, top level
// depends on lbpd_pkg, lbpd_line_ram and lbpd_cell
//
// Usage: labels enter on req_ in raster order, one word per clock; a word is taken
// at a rising edge with req_valid high and req_stall low. For every interior pixel
// whose label differs from a face neighbor, rsp_ delivers its index row*width+column,
// produced when the pixel below it is taken; indices of a frame come out ascending.
// Throughput is one label per clock while the chain is not held. A result word passes
// the line buffer read at the edge that takes the label completing it, then four compare
// cells (one neighbor each) and the output register. Pixels that yield no result
// are dropped inside the chain.
// When rsp_stall is high while a result waits, the whole chain holds and req_stall
// goes high in the same cycle; it drops as soon as the output word is taken.
// csr_ writes set the image width (index 0) or height (index 1), saturate them into
// the legal range and restart the frame; write only while the block is idle.
// Reset (synchronous) sets width 640, height 480 and empties the chain; the line
// buffers are not cleared, every entry is written before it is read in a frame.
`default_nettype none

module label_border_pixel_detector_core #(
   parameter int MAX_WIDTH  = 2048,
   parameter int LABEL_BITS = 16
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  wire [lbpd_pkg::LABEL_PORT_BITS-1:0]    req_label,
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output logic [lbpd_pkg::IDX_BITS-1:0]          rsp_pixel_index,
   input  wire                                    csr_write_enable,
   input  wire [lbpd_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire [lbpd_pkg::DIM_BITS-1:0]           csr_write_data
);

   import lbpd_pkg::*;

   localparam int ADDR_BITS   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WIDTH_LIMIT = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
   localparam int WIDTH_RESET = (WIDTH_DEFAULT > WIDTH_LIMIT) ? WIDTH_LIMIT : WIDTH_DEFAULT;

   // configuration
   logic [DIM_BITS-1:0] width_ff;
   logic [DIM_BITS-1:0] height_ff;

   // position of the next pixel
   logic [COORD_BITS-1:0] col_ff, col_in;
   logic [COORD_BITS-1:0] row_ff, row_in;
   logic [IDX_BITS-1:0]   lin_ff, lin_in;
   logic [DIM_BITS-1:0]   col_next;
   logic [DIM_BITS-1:0]   row_next;
   logic                  col_last;
   logic                  row_last;

   // handshake
   logic pipe_en;
   logic accept;

   // line buffer access
   logic [LABEL_BITS-1:0] cur_label;
   logic [ADDR_BITS-1:0]  addr_c;
   logic [ADDR_BITS-1:0]  addr_r;
   logic [LABEL_BITS-1:0] mid_c_rd;
   logic [LABEL_BITS-1:0] mid_r_rd;
   logic [LABEL_BITS-1:0] up_rd;

   // read stage
   logic                  b_valid_ff, b_valid_in;
   logic                  b_test_ff;
   logic [LABEL_BITS-1:0] b_cur_ff;
   logic [ADDR_BITS-1:0]  b_addr_ff;
   logic [IDX_BITS-1:0]   b_idx_ff;
   logic [LABEL_BITS-1:0] left_ff;

   // compare chain
   cell_ctl_type          ctl_chain    [NB_COUNT + 1];
   logic [LABEL_BITS-1:0] centre_chain [NB_COUNT + 1];
   logic [LABEL_BITS-1:0] nb_chain     [NB_COUNT + 1][NB_COUNT];

   // output register
   logic                rsp_valid_ff;
   logic [IDX_BITS-1:0] rsp_idx_ff;

   // handshake: the chain moves whenever the output register can take a word
   assign pipe_en   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !pipe_en;
   assign accept    = req_valid && pipe_en;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_BITS'(WIDTH_RESET);
         height_ff <= DIM_BITS'(HEIGHT_DEFAULT);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_ff <= clamp_dim(csr_write_data, DIM_BITS'(WIDTH_LIMIT));
            end
            CSR_IMAGE_HEIGHT: begin
               height_ff <= clamp_dim(csr_write_data, DIM_BITS'(DIM_MAX));
            end
            default: begin
               width_ff <= width_ff;
            end
         endcase
      end
   end

   // raster counters
   assign col_next = {1'b0, col_ff} + 1'b1;
   assign row_next = {1'b0, row_ff} + 1'b1;
   assign col_last = col_next >= width_ff;
   assign row_last = row_next >= height_ff;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      lin_in = lin_ff;
      if (csr_write_enable) begin
         col_in = '0;
         row_in = '0;
         lin_in = '0;
      end else if (accept) begin
         if (col_last) begin
            col_in = '0;
            if (row_last) begin
               row_in = '0;
            end else begin
               row_in = row_next[COORD_BITS-1:0];
            end
         end else begin
            col_in = col_next[COORD_BITS-1:0];
         end
         if (col_last && row_last) begin
            lin_in = '0;
         end else begin
            lin_in = lin_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         lin_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         lin_ff <= lin_in;
      end
   end

   // line buffer addresses; the right neighbor falls back to the center at the row end
   assign cur_label = LABEL_BITS'(req_label);
   assign addr_c    = ADDR_BITS'(col_ff);
   assign addr_r    = (col_next < width_ff) ? ADDR_BITS'(col_next) : addr_c;

   // previous row: center and right neighbor, current label overwrites the center
   lbpd_line_ram #(
      .DEPTH     (MAX_WIDTH),
      .DATA_BITS (LABEL_BITS)
   ) u_mid_ram (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (addr_c),
      .wr_data   (cur_label),
      .rd_en     (accept),
      .rd_a_addr (addr_c),
      .rd_b_addr (addr_r),
      .rd_a_data (mid_c_rd),
      .rd_b_data (mid_r_rd)
   );

   // row above the tested one, refilled from the center as the read stage moves on
   lbpd_line_ram #(
      .DEPTH     (MAX_WIDTH),
      .DATA_BITS (LABEL_BITS)
   ) u_up_ram (
      .clock     (clock),
      .wr_en     (pipe_en && b_valid_ff),
      .wr_addr   (b_addr_ff),
      .wr_data   (mid_c_rd),
      .rd_en     (accept),
      .rd_a_addr (addr_c),
      .rd_b_addr (addr_c),
      .rd_a_data (up_rd),
      .rd_b_data ()
   );

   // read stage valid
   assign b_valid_in = accept ? 1'b1 : (pipe_en ? 1'b0 : b_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   // read stage payload: interior test and index of the pixel one row up
   always_ff @(posedge clock) begin
      if (accept) begin
         b_cur_ff  <= cur_label;
         b_addr_ff <= addr_c;
         b_test_ff <= (row_ff >= COORD_BITS'(2)) && (col_ff != '0) && (col_next < width_ff);
         b_idx_ff  <= lin_ff - IDX_BITS'(width_ff);
      end
   end

   // left neighbor: center of the previous pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else if (pipe_en && b_valid_ff) begin
         left_ff <= mid_c_rd;
      end
   end

   // head of the compare chain
   assign ctl_chain[0].valid = b_valid_ff && b_test_ff;
   assign ctl_chain[0].hit   = 1'b0;
   assign ctl_chain[0].idx   = b_idx_ff;
   assign centre_chain[0]    = mid_c_rd;
   assign nb_chain[0][0]     = left_ff;
   assign nb_chain[0][1]     = mid_r_rd;
   assign nb_chain[0][2]     = up_rd;
   assign nb_chain[0][3]     = b_cur_ff;

   // one cell per neighbor
   for (genvar k = 0; k < NB_COUNT; k++) begin : g_cell
      lbpd_cell #(
         .LABEL_BITS (LABEL_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (pipe_en),
         .ctl_i    (ctl_chain[k]),
         .centre_i (centre_chain[k]),
         .nb_i     (nb_chain[k]),
         .ctl_o    (ctl_chain[k + 1]),
         .centre_o (centre_chain[k + 1]),
         .nb_o     (nb_chain[k + 1])
      );
   end

   // output register, only border pixels enter
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= ctl_chain[NB_COUNT].valid && ctl_chain[NB_COUNT].hit;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_idx_ff <= ctl_chain[NB_COUNT].idx;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_index = rsp_idx_ff;

`ifndef SYNTHESIS
   // column stays inside the row
   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, col_ff} < width_ff))
      else $error("column counter beyond image width");

   // linear index is zero exactly at the frame start
   a_lin_origin: assert property (@(posedge clock) disable iff (reset)
      ((col_ff == '0 && row_ff == '0) == (lin_ff == '0)))
      else $error("linear index out of step with row and column");

   // a register write restarts the frame
   a_cfg_restart: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> (col_ff == '0 && row_ff == '0 && lin_ff == '0))
      else $error("frame not restarted after register write");

   // upper line refill never hits the address being read
   a_up_ram_hazard: assert property (@(posedge clock) disable iff (reset)
      (accept && b_valid_ff) |-> (addr_c != b_addr_ff))
      else $error("upper line read and write collide");
`endif

endmodule

`default_nettype wire

[dv/label_border_pixel_detector_core_tb.sv]
`timescale 1ns / 1ps
// label_border_pixel_detector_core_tb: self-checking bench for the label border detector
// streams label images into req_, predicts border pixel indices, checks each rsp_ word
// depends on lbpd_pkg and label_border_pixel_detector_core

module label_border_pixel_detector_core_tb;
   import lbpd_pkg::*;

   typedef logic [LABEL_PORT_BITS-1:0] label_t;
   typedef logic [IDX_BITS-1:0]        index_t;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 12;
   localparam int IDLE_PCT     = 21;    // receiver stall rate
   localparam int SEND_GAP_PCT = 14;    // chance of a sender gap
   localparam int CHAIN_SLACK  = 12;    // margin for results still in the chain
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 300;
   localparam int MAX_REPORTS  = 40;

   logic                      clock            = 1'b0;
   logic                      reset            = 1'b1;
   logic                      req_valid        = 1'b0;
   logic                      req_stall;
   label_t                    req_label        = '0;
   logic                      rsp_valid;
   logic                      rsp_stall        = 1'b0;
   index_t                    rsp_pixel_index;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index        = CSR_IMAGE_WIDTH;
   logic [DIM_BITS-1:0]       csr_write_data   = '0;

   // predicted geometry, position and line buffers
   int unsigned img_width;
   int unsigned img_height;
   int unsigned col_pos;
   int unsigned row_pos;
   label_t      upper_buf [DIM_MAX];
   label_t      middle_buf [DIM_MAX];
   label_t      left_lbl;

   // border indices still to come out of the block
   index_t      border_q [$];
   index_t      expected_idx;

   int          mismatches = 0;
   bit          calm = 1'b0;
   int unsigned idle_cycles = 0;

   // label image generator: blocky regions plus noise
   label_t      palette [4];
   int unsigned blk_w;
   int unsigned blk_h;
   int unsigned noise_pct;

   label_border_pixel_detector_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_label        (req_label),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_index  (rsp_pixel_index),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void reset_predictor();
      img_width  = WIDTH_DEFAULT;
      img_height = HEIGHT_DEFAULT;
      col_pos    = 0;
      row_pos    = 0;
      left_lbl   = '0;
      foreach (upper_buf[i]) begin
         upper_buf[i]  = '0;
         middle_buf[i] = '0;
      end
   endfunction

   // a write saturates the dimension and restarts the frame
   function automatic void apply_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                                     input logic [DIM_BITS-1:0] val);
      int unsigned dim;
      dim = val;
      if (dim < DIM_MIN) begin
         dim = DIM_MIN;
      end else if (dim > DIM_MAX) begin
         dim = DIM_MAX;
      end
      if (idx == CSR_IMAGE_WIDTH) begin
         img_width = dim;
      end else begin
         img_height = dim;
      end
      col_pos = 0;
      row_pos = 0;
   endfunction

   // test the pixel above the incoming one against its four face neighbors
   function automatic void predict_border(input label_t lbl);
      int unsigned x;
      int unsigned y;
      label_t      center_lbl;
      label_t      above_lbl;
      label_t      right_lbl;
      x = (col_pos >= img_width) ? img_width - 1 : col_pos;
      y = (row_pos >= img_height) ? img_height - 1 : row_pos;
      center_lbl = middle_buf[x];
      above_lbl  = upper_buf[x];
      right_lbl  = (x + 1 < img_width) ? middle_buf[x + 1] : center_lbl;
      if (y >= 2 && x >= 1 && x + 1 < img_width) begin
         if (left_lbl != center_lbl || right_lbl != center_lbl ||
             above_lbl != center_lbl || lbl != center_lbl) begin
            border_q = {border_q, index_t'((y - 1) * img_width + x)};
         end
      end
      // shift the line buffers: middle row moves up, incoming label enters middle
      left_lbl      = center_lbl;
      upper_buf[x]  = center_lbl;
      middle_buf[x] = lbl;
      x++;
      if (x >= img_width) begin
         x = 0;
         y++;
         if (y >= img_height) begin
            y = 0;
         end
      end
      col_pos = x;
      row_pos = y;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("%0t mismatch: %s", $time, what);
      end
   endtask

   // compare each accepted result word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (border_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word, pixel_index %0d", rsp_pixel_index));
         end else begin
            expected_idx = border_q.pop_front();
            if (rsp_pixel_index !== expected_idx) begin
               report_mismatch($sformatf("pixel_index %0d, expected %0d",
                                         rsp_pixel_index, expected_idx));
            end
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic void shuffle_palette();
      foreach (palette[i]) begin
         case ($urandom_range(0, 9))
            0:       palette[i] = '0;
            1:       palette[i] = '1;
            2:       palette[i] = palette[0];
            default: palette[i] = label_t'($urandom);
         endcase
      end
      blk_w     = $urandom_range(1, 6);
      blk_h     = $urandom_range(1, 4);
      noise_pct = $urandom_range(0, 10);
   endfunction

   function automatic label_t pick_label(input int unsigned x, input int unsigned y);
      if ($urandom_range(0, 99) < noise_pct) begin
         return label_t'($urandom);
      end
      return palette[((x / blk_w) + 3 * (y / blk_h)) % 4];
   endfunction

   // register value, now and then below the legal range
   function automatic logic [DIM_BITS-1:0] pick_dim(input int unsigned hi);
      if ($urandom_range(0, 9) == 0) begin
         return DIM_BITS'($urandom_range(0, DIM_MIN - 1));
      end
      return DIM_BITS'($urandom_range(DIM_MIN, hi));
   endfunction

   // one word on req_, held until taken
   task automatic send_label(input label_t lbl);
      if (!calm && $urandom_range(0, 99) < SEND_GAP_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_label <= lbl;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predict_border(lbl);
   endtask

   task automatic stream_pixels(input int unsigned count);
      repeat (count) send_label(pick_label(col_pos, row_pos));
   endtask

   // wait until every predicted word has come back and the chain has emptied
   task automatic settle_block();
      req_valid <= 1'b0;
      while (border_q.size() != 0) @(posedge clock);
      repeat (CHAIN_SLACK) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [DIM_BITS-1:0] val);
      settle_block();
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      apply_csr(idx, val);
   endtask

   // ---------------------------------------------------------------- tests

   // reset geometry of 640 columns, enough rows for border words
   task automatic test_reset_defaults();
      shuffle_palette();
      stream_pixels(2 * img_width + 4);
      settle_block();
   endtask

   // narrow image where each interior pixel differs through one neighbor only
   task automatic test_directed_patterns();
      label_t tall [18];
      tall = '{16'h0000, 16'hFFFF, 16'h0000,    // above differs
               16'h0000, 16'h0000, 16'h0000,
               16'h0000, 16'h0000, 16'h8000,    // right differs
               16'h0001, 16'h0000, 16'h0000,    // left differs
               16'h0000, 16'h0000, 16'h0000,
               16'h0000, 16'h7FFF, 16'h0000};   // below differs
      write_csr(CSR_IMAGE_WIDTH, 12'd0);        // saturates up to 3
      write_csr(CSR_IMAGE_HEIGHT, 12'd6);
      foreach (tall[i]) begin
         send_label(tall[i]);
      end
      // flat minimal frame gives no border at all
      write_csr(CSR_IMAGE_HEIGHT, 12'd1);
      repeat (9) send_label(16'h1234);
      settle_block();
   endtask

   // widest row and the first rows of the tallest frame
   task automatic test_extreme_sizes();
      write_csr(CSR_IMAGE_WIDTH, 12'hFFF);      // saturates down to the widest row
      write_csr(CSR_IMAGE_HEIGHT, 12'd0);
      shuffle_palette();
      stream_pixels(24);
      write_csr(CSR_IMAGE_WIDTH, 12'd3);
      write_csr(CSR_IMAGE_HEIGHT, 12'd2048);
      shuffle_palette();
      stream_pixels(img_width * 12);
      settle_block();
   endtask

   // small random geometries, whole frames back to back, some cut short
   task automatic test_random_frames();
      int unsigned sent;
      int unsigned phase;
      int unsigned pixels;
      int unsigned half;
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS || phase < 5) begin
         calm = (phase == 2);
         if (calm) begin
            write_csr(CSR_IMAGE_WIDTH, 12'd16);
            write_csr(CSR_IMAGE_HEIGHT, 12'd6);
         end else begin
            case ($urandom_range(0, 3))
               0: write_csr(CSR_IMAGE_WIDTH, pick_dim($urandom_range(0, 7) == 0 ? 24 : 12));
               1: write_csr(CSR_IMAGE_HEIGHT, pick_dim(8));
               default: begin
                  write_csr(CSR_IMAGE_HEIGHT, pick_dim(8));
                  write_csr(CSR_IMAGE_WIDTH, pick_dim($urandom_range(0, 7) == 0 ? 24 : 12));
               end
            endcase
         end
         repeat ($urandom_range(1, 2)) begin
            shuffle_palette();
            pixels = img_width * img_height;
            if ($urandom_range(0, 99) < 15) begin
               pixels = $urandom_range(1, pixels - 1);
            end
            if (phase == 4) begin
               // hold the sender mid-frame until all border words are back
               half = pixels / 2;
               stream_pixels(half);
               settle_block();
               stream_pixels(pixels - half);
            end else begin
               stream_pixels(pixels);
            end
            sent += pixels;
         end
         phase++;
      end
      calm = 1'b0;
   endtask

   initial begin
      reset_predictor();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_patterns();
      test_extreme_sizes();
      test_random_frames();
      settle_block();
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/lbpd_pkg.sv
rtl/lbpd_line_ram.sv
rtl/lbpd_cell.sv
rtl/label_border_pixel_detector_core.sv
dv/label_border_pixel_detector_core_tb.sv
